>>> rtl/sof_length_xor_fcs_deframer_top_defines.svh
// Assertion macros shared by the deframer checker.
`ifndef SOF_LENGTH_XOR_FCS_DEFRAMER_TOP_DEFINES_SVH
`define SOF_LENGTH_XOR_FCS_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define SOFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sofd check failed");

// next-cycle implication
`define SOFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sofd check failed");

`endif

>>> rtl/sofd_pkg.sv
// Shared constants and types of the start-of-frame deframer.
package sofd_pkg;

   localparam int BUF_BYTES = 256;
   localparam int ADDR_W    = $clog2(BUF_BYTES);

   localparam logic [7:0] SOF_BYTE   = 8'hFE;
   localparam logic [7:0] RADIO_CODE = 8'h84;
   localparam logic [7:0] RSSI_SHIFT = 8'd73;
   localparam logic [7:0] LQI_MASK   = 8'h7F;

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic       has_rsp;
      logic       is_frame;
      logic [7:0] code;
      logic [7:0] plen;
      logic       radio;
      logic [7:0] rssi;
      logic [6:0] lqi;
      logic       read_hit;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } ram_req_type;

endpackage

>>> rtl/sofd_frame_ram.sv
// Single-port frame store with registered read data.
module sofd_frame_ram (
   input  logic                 clock,
   input  sofd_pkg::ram_req_type ram_req,
   output logic [7:0]           rdata
);

   logic [7:0] mem [sofd_pkg::BUF_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      if (ram_req.rd_en) begin
         rdata_ff <= mem[ram_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/sofd_parser.sv
// Frame parser: hunt, length, body with running XOR check, store access.
module sofd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  action,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            read_index,
   output sofd_pkg::rsp_type     rsp,
   output sofd_pkg::ram_req_type ram_req
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] bytes_taken_ff, bytes_taken_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] code_ff, code_in;
   logic [7:0] rssi_raw_ff, rssi_raw_in;
   logic [7:0] lqi_raw_ff, lqi_raw_in;
   logic [7:0] last_len_ff, last_len_in;

   logic       byte_acc;
   logic [8:0] ridx_p1;
   logic       too_long;
   logic       good;
   logic [7:0] plen;
   logic       radio;

   assign byte_acc = accept && (action == sofd_pkg::ACT_BYTE);
   assign ridx_p1  = {1'b0, read_index} + 9'd1;
   assign too_long = {1'b0, rx_byte} > 9'(sofd_pkg::BUF_BYTES - 1);
   assign plen     = frame_length_ff - 8'd1;
   assign radio    = (code_ff == sofd_pkg::RADIO_CODE) && (frame_length_ff >= 8'd3);

   always_comb begin
      phase_in        = phase_ff;
      frame_length_in = frame_length_ff;
      bytes_taken_in  = bytes_taken_ff;
      check_in        = check_ff;
      code_in         = code_ff;
      rssi_raw_in     = rssi_raw_ff;
      lqi_raw_in      = lqi_raw_ff;
      last_len_in     = last_len_ff;
      good            = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.rd_en   = accept && (action == sofd_pkg::ACT_READ);
      ram_req.addr    = ridx_p1[sofd_pkg::ADDR_W-1:0];
      ram_req.wdata   = rx_byte;
      if (byte_acc) begin
         unique case (phase_ff)
            sofd_pkg::PH_LEN: begin
               frame_length_in = rx_byte;
               bytes_taken_in  = 8'd0;
               check_in        = rx_byte;
               phase_in        = (rx_byte == 8'd0 || too_long) ?
                                 sofd_pkg::PH_HUNT : sofd_pkg::PH_BODY;
            end
            sofd_pkg::PH_BODY: begin
               ram_req.wr_en = 1'b1;
               ram_req.addr  = bytes_taken_ff[sofd_pkg::ADDR_W-1:0];
               if (bytes_taken_ff != frame_length_ff) begin
                  check_in       = check_ff ^ rx_byte;
                  bytes_taken_in = bytes_taken_ff + 8'd1;
                  if (bytes_taken_ff == 8'd0) begin
                     code_in = rx_byte;
                  end
                  if (bytes_taken_ff == 8'd1) begin
                     rssi_raw_in = rx_byte;
                  end
                  if (bytes_taken_ff == 8'd2) begin
                     lqi_raw_in = rx_byte;
                  end
               end else begin
                  phase_in = sofd_pkg::PH_HUNT;
                  good     = (check_ff == rx_byte) && (code_ff != 8'd0);
                  if (good) begin
                     last_len_in = plen;
                  end
               end
            end
            default: begin
               phase_in = (rx_byte == sofd_pkg::SOF_BYTE) ? sofd_pkg::PH_LEN : sofd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      rsp          = '0;
      rsp.has_rsp  = good || ram_req.rd_en;
      rsp.is_frame = good;
      rsp.read_hit = ram_req.rd_en && (read_index < last_len_ff) &&
                     (ridx_p1 < 9'(sofd_pkg::BUF_BYTES));
      if (good) begin
         rsp.code  = code_ff;
         rsp.plen  = plen;
         rsp.radio = radio;
         if (radio) begin
            rsp.rssi = rssi_raw_ff - sofd_pkg::RSSI_SHIFT;
            rsp.lqi  = 7'(lqi_raw_ff & sofd_pkg::LQI_MASK);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= sofd_pkg::PH_HUNT;
         frame_length_ff <= 8'd0;
         bytes_taken_ff  <= 8'd0;
         check_ff        <= 8'd0;
         code_ff         <= 8'd0;
         rssi_raw_ff     <= 8'd0;
         lqi_raw_ff      <= 8'd0;
         last_len_ff     <= 8'd0;
      end else begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         bytes_taken_ff  <= bytes_taken_in;
         check_ff        <= check_in;
         code_ff         <= code_in;
         rssi_raw_ff     <= rssi_raw_in;
         lqi_raw_ff      <= lqi_raw_in;
         last_len_ff     <= last_len_in;
      end
   end

endmodule

>>> rtl/sof_length_xor_fcs_deframer_top.sv
// Deframer top level: one word per cycle while req_stall is low; a result
// (good frame or read reply) is registered in the first stage, beside the
// registered read of the 256 x 8 single-port frame store, and then in the
// output register. Each word makes at most one store access (a body byte
// writes, a read word reads). rsp_stall backs up through the two stages to
// req_stall.
module sof_length_xor_fcs_deframer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [7:0]        req_rx_byte,
   input  logic [7:0]        req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_frame,
   output logic [7:0]        rsp_response_code,
   output logic [7:0]        rsp_payload_length,
   output logic              rsp_radio_info_valid,
   output logic signed [7:0] rsp_rssi_dbm,
   output logic [6:0]        rsp_link_quality,
   output logic [7:0]        rsp_read_data
);

   logic                  accept;
   logic                  out_load;
   sofd_pkg::rsp_type     p_rsp;
   sofd_pkg::ram_req_type ram_req;
   logic [7:0]            ram_rdata;

   logic                  s1_valid_ff, s1_valid_in;
   sofd_pkg::rsp_type     s1_rsp_ff;
   logic                  out_valid_ff, out_valid_in;
   sofd_pkg::rsp_type     out_rsp_ff;
   logic [7:0]            out_data_ff;

   assign out_load  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !out_load;
   assign accept    = req_valid && !req_stall;

   sofd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_action),
      .rx_byte    (req_rx_byte),
      .read_index (req_read_index),
      .rsp        (p_rsp),
      .ram_req    (ram_req)
   );

   sofd_frame_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff && !out_load;
      if (accept) begin
         s1_valid_in = p_rsp.has_rsp;
      end
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff <= p_rsp;
      end
      if (out_load) begin
         out_rsp_ff  <= s1_rsp_ff;
         out_data_ff <= s1_rsp_ff.read_hit ? ram_rdata : 8'd0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_is_frame         = out_rsp_ff.is_frame;
   assign rsp_response_code    = out_rsp_ff.code;
   assign rsp_payload_length   = out_rsp_ff.plen;
   assign rsp_radio_info_valid = out_rsp_ff.radio;
   assign rsp_rssi_dbm         = out_rsp_ff.rssi;
   assign rsp_link_quality     = out_rsp_ff.lqi;
   assign rsp_read_data        = out_data_ff;

endmodule

>>> rtl/sofd_checker.sv
// Port-level checker of the deframer and its bind to the top level.
`include "sof_length_xor_fcs_deframer_top_defines.svh"

module sofd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_is_frame,
   input logic [7:0]        rsp_response_code,
   input logic [7:0]        rsp_payload_length,
   input logic              rsp_radio_info_valid,
   input logic signed [7:0] rsp_rssi_dbm,
   input logic [6:0]        rsp_link_quality,
   input logic [7:0]        rsp_read_data
);

   logic        rsp_held;
   logic        rsp_reply;
   logic        rsp_frame;
   logic        reply_clear;
   logic        frame_clean;
   logic        radio_clear;
   logic [40:0] rsp_word;

   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_reply   = rsp_valid && !rsp_is_frame;
   assign rsp_frame   = rsp_valid && rsp_is_frame;
   assign reply_clear = (rsp_response_code == 8'd0) && (rsp_payload_length == 8'd0) &&
                        !rsp_radio_info_valid;
   assign frame_clean = (rsp_response_code != 8'd0) && (rsp_read_data == 8'd0);
   assign radio_clear = (rsp_rssi_dbm == 8'sd0) && (rsp_link_quality == 7'd0);
   assign rsp_word    = {rsp_is_frame, rsp_response_code, rsp_payload_length,
                         rsp_radio_info_valid, rsp_rssi_dbm, rsp_link_quality, rsp_read_data};

   `SOFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))
   `SOFD_ASSERT_NOW(a_read_clean, clock, reset, rsp_reply, reply_clear)
   `SOFD_ASSERT_NOW(a_frame_code, clock, reset, rsp_frame, frame_clean)
   `SOFD_ASSERT_NOW(a_radio_zero, clock, reset, rsp_valid && !rsp_radio_info_valid, radio_clear)

endmodule

bind sof_length_xor_fcs_deframer_top sofd_checker u_sofd_checker (.*);

>>> dv/sofd_frame_checker.sv
// Watches both channels of the deframer, predicts each result and compares it.
module sofd_frame_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_action,
   input  logic [7:0]        req_rx_byte,
   input  logic [7:0]        req_read_index,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_is_frame,
   input  logic [7:0]        rsp_response_code,
   input  logic [7:0]        rsp_payload_length,
   input  logic              rsp_radio_info_valid,
   input  logic signed [7:0] rsp_rssi_dbm,
   input  logic [6:0]        rsp_link_quality,
   input  logic [7:0]        rsp_read_data,
   output int                mismatches,
   output int                pending,
   output int                frames_seen,
   output int                replies_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       is_frame;
      logic [7:0] code;
      logic [7:0] plen;
      logic       radio;
      logic [7:0] rssi;
      logic [6:0] lqi;
      logic [7:0] rdata;
   } deframe_result_type;

   logic [1:0]         phase;
   logic [7:0]         frame_len;
   logic [7:0]         body_count;
   logic [7:0]         fcs_acc;
   logic [7:0]         byte_store [0:sofd_pkg::BUF_BYTES-1];
   logic [7:0]         last_plen;
   deframe_result_type expected_q [$];
   int                 err_n;
   int                 frame_n;
   int                 reply_n;

   function automatic bit deframe_word(input logic act, input logic [7:0] b,
                                       input logic [7:0] ridx,
                                       output deframe_result_type r);
      logic [7:0] code;
      logic [7:0] plen;
      r = '0;
      if (act == sofd_pkg::ACT_READ) begin
         if (ridx < last_plen) begin
            r.rdata = byte_store[ridx + 8'd1];
         end
         return 1'b1;
      end
      case (phase)
         sofd_pkg::PH_LEN: begin
            frame_len  = b;
            body_count = 8'd0;
            fcs_acc    = b;
            phase      = (b == 8'd0 || int'(b) > sofd_pkg::BUF_BYTES - 1) ?
                         sofd_pkg::PH_HUNT : sofd_pkg::PH_BODY;
            return 1'b0;
         end
         sofd_pkg::PH_BODY: begin
            byte_store[body_count] = b;
            if (body_count != frame_len) begin
               fcs_acc    = fcs_acc ^ b;
               body_count = body_count + 8'd1;
               return 1'b0;
            end
            phase = sofd_pkg::PH_HUNT;
            code  = byte_store[0];
            plen  = frame_len - 8'd1;
            if (fcs_acc != b || code == 8'd0) begin
               return 1'b0;
            end
            last_plen  = plen;
            r.is_frame = 1'b1;
            r.code     = code;
            r.plen     = plen;
            if (code == sofd_pkg::RADIO_CODE && plen >= 8'd2) begin
               r.radio = 1'b1;
               r.rssi  = byte_store[1] - sofd_pkg::RSSI_SHIFT;
               r.lqi   = byte_store[2][6:0] & sofd_pkg::LQI_MASK[6:0];
            end
            return 1'b1;
         end
         default: begin
            phase = (b == sofd_pkg::SOF_BYTE) ? sofd_pkg::PH_LEN : sofd_pkg::PH_HUNT;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         err_n++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      deframe_result_type want;
      deframe_result_type fresh;
      if (reset) begin
         phase      = sofd_pkg::PH_HUNT;
         frame_len  = 8'd0;
         body_count = 8'd0;
         fcs_acc    = 8'd0;
         last_plen  = 8'd0;
         expected_q.delete();
         err_n      = 0;
         frame_n    = 0;
         reply_n    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               err_n++;
               $display("%0t: result with nothing expected, actual frame %0b code %0h",
                        $time, rsp_is_frame, rsp_response_code);
            end else begin
               want = expected_q.pop_front();
               check_field("is_frame", 8'(want.is_frame), 8'(rsp_is_frame));
               check_field("response_code", want.code, rsp_response_code);
               check_field("payload_length", want.plen, rsp_payload_length);
               check_field("radio_info_valid", 8'(want.radio), 8'(rsp_radio_info_valid));
               check_field("rssi_dbm", want.rssi, rsp_rssi_dbm);
               check_field("link_quality", 8'(want.lqi), 8'(rsp_link_quality));
               check_field("read_data", want.rdata, rsp_read_data);
               if (want.is_frame) frame_n++;
               else reply_n++;
            end
         end
         if (req_valid && !req_stall) begin
            if (deframe_word(req_action, req_rx_byte, req_read_index, fresh)) begin
               expected_q.push_back(fresh);
            end
         end
      end
      mismatches   <= err_n;
      pending      <= expected_q.size();
      frames_seen  <= frame_n;
      replies_seen <= reply_n;
   end

endmodule

>>> dv/sof_length_xor_fcs_deframer_top_test.sv
// Stimulus, clock, reset and verdict for the deframer; the checker does the comparing.
module sof_length_xor_fcs_deframer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_TARGET = 1550;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_action;
   logic [7:0]        req_rx_byte;
   logic [7:0]        req_read_index;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_is_frame;
   logic [7:0]        rsp_response_code;
   logic [7:0]        rsp_payload_length;
   logic              rsp_radio_info_valid;
   logic signed [7:0] rsp_rssi_dbm;
   logic [6:0]        rsp_link_quality;
   logic [7:0]        rsp_read_data;

   int mismatches;
   int pending;
   int frames_seen;
   int replies_seen;
   int words_sent = 0;
   int reads_sent = 0;
   int cycle_count = 0;
   bit calm = 1'b0;
   bit want_hold = 1'b0;
   bit pressured = 1'b0;

   sof_length_xor_fcs_deframer_top u_top (.*);

   sofd_frame_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_word(input logic act, input logic [7:0] b, input logic [7:0] idx);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_rx_byte    <= b;
      req_read_index <= idx;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (act == sofd_pkg::ACT_READ) reads_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(sofd_pkg::ACT_BYTE, b, 8'($urandom_range(0, 254)));
   endtask

   task automatic read_payload(input logic [7:0] idx);
      send_word(sofd_pkg::ACT_READ, 8'($urandom_range(0, 255)), idx);
   endtask

   // p0 and p1 are the first two payload bytes; the rest are random
   task automatic send_frame(input int len, input logic [7:0] code, input logic [7:0] p0,
                             input logic [7:0] p1, input bit bad_fcs, input bit peek);
      logic [7:0] fcs;
      logic [7:0] pb;
      fcs = 8'(len) ^ code;
      send_byte(sofd_pkg::SOF_BYTE);
      send_byte(8'(len));
      send_byte(code);
      for (int i = 0; i < len - 1; i++) begin
         pb  = (i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom_range(0, 255));
         fcs = fcs ^ pb;
         if (peek && $urandom_range(0, 5) == 0) read_payload(8'($urandom_range(0, 15)));
         send_byte(pb);
      end
      if (bad_fcs) fcs = fcs ^ 8'($urandom_range(1, 255));
      send_byte(fcs);
   endtask

   initial begin : sink
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         hold = 0;
         if (want_hold) begin
            hold      = LONG_HOLD;
            want_hold = 1'b0;
         end else if (rsp_valid && !rsp_stall && !calm) begin
            hold = $urandom_range(0, 5);
         end else if (!rsp_valid && !calm && $urandom_range(0, 15) == 0) begin
            hold = $urandom_range(1, 5);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : source
      int pick;
      int len;
      logic [7:0] code;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= sofd_pkg::ACT_BYTE;
      req_rx_byte    <= 8'd0;
      req_read_index <= 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      read_payload(8'd0);
      send_byte(sofd_pkg::SOF_BYTE);
      send_byte(8'd0);
      send_frame(1, sofd_pkg::RADIO_CODE, 8'd0, 8'd0, 1'b0, 1'b0);
      send_frame(3, sofd_pkg::RADIO_CODE, 8'h80, 8'hFF, 1'b0, 1'b0);
      read_payload(8'd0);
      read_payload(8'd2);
      send_frame(1, 8'h05, 8'd0, 8'd0, 1'b1, 1'b0);
      send_frame(1, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0);
      read_payload(8'd0);

      send_frame(255, sofd_pkg::RADIO_CODE, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      read_payload(8'd253);
      read_payload(8'd254);

      while (words_sent < WORD_TARGET) begin
         calm = ($urandom_range(0, 7) == 0);
         if (!pressured && words_sent > 900) begin
            pressured = 1'b1;
            calm      = 1'b1;
            want_hold = 1'b1;
            repeat (6) begin
               send_frame(2, 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)), 8'd0,
                          1'b0, 1'b0);
               read_payload(8'd0);
            end
            continue;
         end
         pick = $urandom_range(0, 99);
         code = ($urandom_range(0, 3) == 0) ? sofd_pkg::RADIO_CODE :
                ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
         if (pick < 55) begin
            send_frame($urandom_range(1, 10), code, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         end else if (pick < 59) begin
            send_frame($urandom_range(11, 40), code, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0, 1'b1);
         end else if (pick < 65) begin
            send_frame($urandom_range(1, 10), code, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b1, 1'b0);
         end else if (pick < 69) begin
            len = $urandom_range(3, 10);
            send_byte(sofd_pkg::SOF_BYTE);
            send_byte(8'(len));
            repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 72) begin
            send_byte(sofd_pkg::SOF_BYTE);
            send_byte(8'd0);
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 4)) begin
               read_payload(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 254)) :
                                                          8'($urandom_range(0, 12)));
            end
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("sent %0d words, %0d of them reads, with random gaps and one long output hold",
               words_sent, reads_sent);
      $display("checked %0d frame results and %0d read replies", frames_seen, replies_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
